// ----- rtl/rpp_pkg.sv -----
// shared constants and codes of the random pick ready pool
`default_nettype none

package rpp_pkg;

    // generator and divider word
    localparam int RAND_W     = 64;
    localparam int RAND_CNT_W = $clog2(RAND_W);

    // payload widths
    localparam int ID_W        = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_IDX_W   = 1;

    // xorshift128+ shift amounts
    localparam int SHIFT_A = 23;
    localparam int SHIFT_B = 18;
    localparam int SHIFT_C = 5;

    // generator words after reset
    localparam logic [RAND_W-1:0] SEED_LOW_RESET  = 64'd1;
    localparam logic [RAND_W-1:0] SEED_HIGH_RESET = 64'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH = 1'b1;

    // input word kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/random_pick_ready_pool_core.sv -----
// random pick ready pool: identifier store with xorshift128+ random removal
//
// input channel (in_valid / in_stall) carries one word: kind and task_id.
// an add appends task_id; a take removes a random entry and moves the last
// entry into the hole. every input word gives exactly one result word on
// the output channel (out_valid / out_stall): taken_id, status, pool_count.
// an add, a full add or an empty take goes from idle straight to the output
// state, which loads the result register; a successful take goes through a
// start state, the bit-serial remainder unit (one quotient bit per cycle), the
// done strobe, two reads and one write on the identifier memory, then the
// output load. one word is worked on at a time; in_stall is high until the
// result is in the output register, which may still be waiting while the next
// word enters. a stalled result holds in the output register; the block waits
// with the following result until it is taken.
// reset empties the pool and loads the generator words with 1 and 2.
// writes to the seed registers (cfg_we, cfg_index, cfg_data) load the
// generator words at once; the user is to make them only while the block
// is idle, as the block itself does not enforce this.
`default_nettype none

module random_pick_ready_pool_core #(
    parameter int POOL_DEPTH = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rpp_pkg::RAND_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              kind,
    input  wire logic [rpp_pkg::ID_W-1:0]          task_id,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [rpp_pkg::ID_W-1:0]               taken_id,
    output logic [rpp_pkg::STATUS_W-1:0]           status,
    output logic [rpp_pkg::COUNT_OUT_W-1:0]        pool_count
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W = $clog2(POOL_DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_RDPICK = 3'd3;
    localparam logic [2:0] S_RDLAST = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]                          state_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [rpp_pkg::RAND_W-1:0]          gen_a_reg;
    logic [rpp_pkg::RAND_W-1:0]          gen_b_reg;
    logic [rpp_pkg::RAND_W-1:0]          gen_t1;
    logic [rpp_pkg::RAND_W-1:0]          gen_t2;
    logic [rpp_pkg::RAND_W-1:0]          gen_b_next;
    logic [IDX_W-1:0]                    pick_reg;
    logic [IDX_W-1:0]                    last_idx;
    logic [rpp_pkg::ID_W-1:0]            res_taken_reg;
    logic [rpp_pkg::STATUS_W-1:0]        res_status_reg;
    logic                                out_valid_reg;
    logic [rpp_pkg::ID_W-1:0]            taken_id_reg;
    logic [rpp_pkg::STATUS_W-1:0]        status_reg;
    logic [rpp_pkg::COUNT_OUT_W-1:0]     pool_count_reg;

    logic [rpp_pkg::ID_W-1:0]            id_mem [POOL_DEPTH];
    logic [rpp_pkg::ID_W-1:0]            rd_data_reg;
    logic [IDX_W-1:0]                    mem_raddr;
    logic [IDX_W-1:0]                    mem_waddr;
    logic [rpp_pkg::ID_W-1:0]            mem_wdata;
    logic                                mem_we;

    logic                                in_accept;
    logic                                pool_full;
    logic                                pool_empty;
    logic                                out_load;
    logic                                div_start;
    logic                                div_done;
    logic [CNT_W-1:0]                    div_rem;
    logic [rpp_pkg::RAND_W-1:0]          rand_sum;

    assign in_accept  = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign pool_full  = (count_reg == CNT_W'(POOL_DEPTH));
    assign pool_empty = (count_reg == '0);
    assign last_idx   = IDX_W'(count_reg - 1'b1);
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);
    assign div_start  = (state_reg == S_START);

    // xorshift128+ step; the new first word is the old second word
    always_comb
    begin
        gen_t1     = gen_a_reg ^ (gen_a_reg << rpp_pkg::SHIFT_A);
        gen_t2     = gen_t1 ^ (gen_t1 >> rpp_pkg::SHIFT_B);
        gen_b_next = gen_t2 ^ gen_b_reg ^ (gen_b_reg >> rpp_pkg::SHIFT_C);
    end

    // new b plus old b, which now sits in gen_a_reg
    assign rand_sum = gen_a_reg + gen_b_reg;

    rpp_mod_unit #(
        .CNT_W (CNT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_sum),
        .divisor   (count_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // memory port selection
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pick_reg;
        mem_wdata = rd_data_reg;
        mem_raddr = pick_reg;
        if (state_reg == S_IDLE)
        begin
            mem_we    = in_accept && (kind == rpp_pkg::KIND_ADD) && !pool_full;
            mem_waddr = IDX_W'(count_reg);
            mem_wdata = task_id;
        end
        else if (state_reg == S_RDLAST)
        begin
            mem_raddr = last_idx;
        end
        else if (state_reg == S_WRITE)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= id_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            gen_a_reg     <= rpp_pkg::SEED_LOW_RESET;
            gen_b_reg     <= rpp_pkg::SEED_HIGH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= S_OUT;
                        if (kind == rpp_pkg::KIND_ADD)
                        begin
                            if (!pool_full)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                        else if (!pool_empty)
                        begin
                            gen_a_reg <= gen_b_reg;
                            gen_b_reg <= gen_b_next;
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RDPICK;
                    end
                end
                S_RDPICK:
                begin
                    state_reg <= S_RDLAST;
                end
                S_RDLAST:
                begin
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    count_reg <= count_reg - 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cfg_we)
            begin
                if (cfg_index == rpp_pkg::REG_SEED_LOW)
                begin
                    gen_a_reg <= cfg_data;
                end
                else if (cfg_index == rpp_pkg::REG_SEED_HIGH)
                begin
                    gen_b_reg <= cfg_data;
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result staging and output word registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_accept)
        begin
            res_taken_reg <= '0;
            if (kind == rpp_pkg::KIND_ADD)
            begin
                res_status_reg <= pool_full ? rpp_pkg::ST_FULL : rpp_pkg::ST_ADDED;
            end
            else
            begin
                res_status_reg <= pool_empty ? rpp_pkg::ST_EMPTY : rpp_pkg::ST_TAKEN;
            end
        end
        if (state_reg == S_DIV && div_done)
        begin
            pick_reg <= IDX_W'(div_rem);
        end
        if (state_reg == S_RDLAST)
        begin
            res_taken_reg <= rd_data_reg;
        end
        if (out_load)
        begin
            taken_id_reg   <= res_taken_reg;
            status_reg     <= res_status_reg;
            pool_count_reg <= rpp_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign taken_id   = taken_id_reg;
    assign status     = status_reg;
    assign pool_count = pool_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(POOL_DEPTH))
        else $error("pool count above depth");

    a_empty_keeps_gen: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (kind == rpp_pkg::KIND_TAKE) && pool_empty && !cfg_we
        |=> $stable(gen_a_reg) && $stable(gen_b_reg))
        else $error("empty take moved the generator");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDPICK) |-> (CNT_W'(pick_reg) < count_reg))
        else $error("picked index outside the pool");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && (state_reg != S_OUT) |=> !out_valid_reg)
        else $error("taken result word still shown");

endmodule

`default_nettype wire

// ----- rtl/rpp_mod_unit.sv -----
// bit-serial restoring remainder of a 64-bit word by a narrow divisor
`default_nettype none

module rpp_mod_unit #(
    parameter int CNT_W = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rpp_pkg::RAND_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]          divisor,
    output logic                           done,
    output logic [CNT_W-1:0]               remainder
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [rpp_pkg::RAND_CNT_W-1:0]  bit_cnt_reg;
    logic [rpp_pkg::RAND_W-1:0]      dvd_reg;
    logic [CNT_W-1:0]                dsr_reg;
    logic [CNT_W-1:0]                rem_reg;
    logic [CNT_W-1:0]                rem_next;
    logic [CNT_W:0]                  trial;
    logic [CNT_W:0]                  diff;

    // shift in the next dividend bit, keep the difference if it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[rpp_pkg::RAND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[CNT_W-1:0];
        end
        else
        begin
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg    <= 1'b1;
                bit_cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == rpp_pkg::RAND_CNT_W'(rpp_pkg::RAND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[rpp_pkg::RAND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- verif/tb_random_pick_ready_pool_core.sv -----
// testbench for random_pick_ready_pool_core: predicted results checked word by word
`timescale 1ns / 1ps

module tb_random_pick_ready_pool_core;

    localparam int POOL_DEPTH   = 64;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 500;
    localparam int TAIL_CYCLES  = 100;

    typedef struct packed {
        logic                     op;
        logic [rpp_pkg::ID_W-1:0] id;
    } pool_word_t;

    typedef struct packed {
        logic [rpp_pkg::ID_W-1:0]        taken_id;
        logic [rpp_pkg::STATUS_W-1:0]    status;
        logic [rpp_pkg::COUNT_OUT_W-1:0] pool_count;
    } pool_result_t;

    logic                            clk;
    logic                            rst_n      = 1'b0;
    logic                            cfg_we     = 1'b0;
    logic [rpp_pkg::CFG_IDX_W-1:0]   cfg_index  = rpp_pkg::REG_SEED_LOW;
    logic [rpp_pkg::RAND_W-1:0]      cfg_data   = '0;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic                            kind       = rpp_pkg::KIND_ADD;
    logic [rpp_pkg::ID_W-1:0]        task_id    = '0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [rpp_pkg::ID_W-1:0]        taken_id;
    logic [rpp_pkg::STATUS_W-1:0]    status;
    logic [rpp_pkg::COUNT_OUT_W-1:0] pool_count;

    // predicted pool contents and generator
    logic [rpp_pkg::ID_W-1:0]   pool_ids [POOL_DEPTH];
    int unsigned                pool_len;
    logic [rpp_pkg::RAND_W-1:0] gen_a;
    logic [rpp_pkg::RAND_W-1:0] gen_b;

    pool_word_t   pending_words [$];
    pool_result_t pending_results [$];

    int  err_cnt        = 0;
    int  cycle_cnt      = 0;
    int  send_idle_pct  = 28;
    int  recv_stall_pct = 28;
    int  hold_left      = 0;
    bit  hold_arm       = 1'b0;
    bit  word_taken     = 1'b0;

    random_pick_ready_pool_core #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .task_id    (task_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .taken_id   (taken_id),
        .status     (status),
        .pool_count (pool_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial
    begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("tb_random_pick_ready_pool_core: done, errors");
        $finish;
    end

    // xorshift128+ step; returns new high word plus old high word
    function automatic logic [rpp_pkg::RAND_W-1:0] xorshift_next();
        logic [rpp_pkg::RAND_W-1:0] t;
        t = gen_a ^ (gen_a << rpp_pkg::SHIFT_A);
        t = t ^ (t >> rpp_pkg::SHIFT_B);
        t = t ^ gen_b ^ (gen_b >> rpp_pkg::SHIFT_C);
        gen_a = gen_b;
        gen_b = t;
        return t + gen_a;
    endfunction

    function automatic pool_result_t pool_step(input logic op,
                                               input logic [rpp_pkg::ID_W-1:0] id);
        pool_result_t               r;
        logic [rpp_pkg::RAND_W-1:0] rnd;
        logic [rpp_pkg::RAND_W-1:0] len_w;
        int unsigned                pick;
        r.taken_id = '0;
        if (op == rpp_pkg::KIND_ADD)
        begin
            if (pool_len >= POOL_DEPTH)
            begin
                r.status = rpp_pkg::ST_FULL;
            end
            else
            begin
                pool_ids[pool_len] = id;
                pool_len++;
                r.status = rpp_pkg::ST_ADDED;
            end
        end
        else if (pool_len == 0)
        begin
            // empty take leaves the generator alone
            r.status = rpp_pkg::ST_EMPTY;
        end
        else
        begin
            rnd = xorshift_next();
            len_w = {32'd0, pool_len};
            pick = 32'(rnd % len_w);
            r.taken_id = pool_ids[pick];
            pool_ids[pick] = pool_ids[pool_len - 1];
            pool_len--;
            r.status = rpp_pkg::ST_TAKEN;
        end
        r.pool_count = pool_len[rpp_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    // input side: predict on acceptance
    always @(posedge clk)
    begin : predict_words
        pool_result_t p;
        if (rst_n && in_valid && !in_stall)
        begin
            p = pool_step(kind, task_id);
            pending_results = {pending_results, p};
            word_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : drive_words
        pool_word_t w;
        if (rst_n && (!in_valid || word_taken))
        begin
            word_taken = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                kind     <= w.op;
                task_id  <= w.id;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output side: random stalls, plus a long hold-off when armed
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_arm)
        begin
            hold_arm = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        pool_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: taken_id %h status %0d pool_count %0d",
                       taken_id, status, pool_count);
                err_cnt++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (taken_id !== e.taken_id)
                begin
                    $error("taken_id mismatch: expected %h, actual %h", e.taken_id, taken_id);
                    err_cnt++;
                end
                if (status !== e.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", e.status, status);
                    err_cnt++;
                end
                if (pool_count !== e.pool_count)
                begin
                    $error("pool_count mismatch: expected %0d, actual %0d",
                           e.pool_count, pool_count);
                    err_cnt++;
                end
            end
        end
    end

    task automatic load_seed(input logic [rpp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rpp_pkg::RAND_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        // a seed write loads its generator word at once
        if (idx == rpp_pkg::REG_SEED_LOW)
        begin
            gen_a = value;
        end
        else
        begin
            gen_b = value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_word(input logic op, input logic [rpp_pkg::ID_W-1:0] id);
        pool_word_t w;
        w.op = op;
        w.id = id;
        pending_words = {pending_words, w};
    endtask

    task automatic queue_random(input int count, input int add_pct);
        for (int i = 0; i < count; i++)
        begin
            queue_word(($urandom_range(99) < add_pct) ? rpp_pkg::KIND_ADD : rpp_pkg::KIND_TAKE,
                       $urandom());
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || pending_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        gen_a    = rpp_pkg::SEED_LOW_RESET;
        gen_b    = rpp_pkg::SEED_HIGH_RESET;
        pool_len = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset seeds: empty take, extreme ids, drain to empty
        queue_word(rpp_pkg::KIND_TAKE, $urandom());
        queue_word(rpp_pkg::KIND_ADD, 32'h0000_0000);
        queue_word(rpp_pkg::KIND_ADD, 32'hFFFF_FFFF);
        queue_word(rpp_pkg::KIND_ADD, 32'h8000_0001);
        queue_word(rpp_pkg::KIND_ADD, $urandom());
        queue_word(rpp_pkg::KIND_ADD, $urandom());
        repeat (5) queue_word(rpp_pkg::KIND_TAKE, $urandom());
        queue_word(rpp_pkg::KIND_TAKE, $urandom());
        wait_idle();

        // all-zero seed: every take picks entry 0
        load_seed(rpp_pkg::REG_SEED_LOW, 64'd0);
        load_seed(rpp_pkg::REG_SEED_HIGH, 64'd0);
        repeat (3) queue_word(rpp_pkg::KIND_ADD, $urandom());
        repeat (4) queue_word(rpp_pkg::KIND_TAKE, $urandom());
        wait_idle();

        // all-ones seed, add-heavy so the pool fills and drops words
        load_seed(rpp_pkg::REG_SEED_LOW, '1);
        load_seed(rpp_pkg::REG_SEED_HIGH, '1);
        queue_random(220, 85);
        wait_idle();

        // random seed, no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_seed(rpp_pkg::REG_SEED_LOW, {$urandom(), $urandom()});
        load_seed(rpp_pkg::REG_SEED_HIGH, {$urandom(), $urandom()});
        queue_random(200, 50);
        wait_idle();

        // take-heavy, drains to empty; receiver holds off for a while
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        load_seed(rpp_pkg::REG_SEED_LOW, {$urandom(), $urandom()});
        load_seed(rpp_pkg::REG_SEED_HIGH, 64'd1);
        queue_random(200, 25);
        hold_arm = 1'b1;
        wait_idle();

        load_seed(rpp_pkg::REG_SEED_LOW, 64'h8000_0000_0000_0000);
        load_seed(rpp_pkg::REG_SEED_HIGH, {$urandom(), $urandom()});
        queue_random(180, 70);
        hold_arm = 1'b1;
        wait_idle();

        // catch any stray result words
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("tb_random_pick_ready_pool_core: done, clean");
        end
        else
        begin
            $display("tb_random_pick_ready_pool_core: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rpp_pkg.sv
rtl/rpp_mod_unit.sv
rtl/random_pick_ready_pool_core.sv
verif/tb_random_pick_ready_pool_core.sv
